// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property failed");

`endif

// File: hw/rtl/hpid_pkg.sv
// Types, constants and register codes for the heater PID controller.
// No dependencies; imported by every module of the block.
package hpid_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [15:0] GAIN_PROP_RST   = 16'd2560;
    localparam logic [15:0] GAIN_INTEG_RST  = 16'd26;
    localparam logic [15:0] GAIN_DERIV_RST  = 16'd512;
    localparam logic [8:0]  NORMAL_TGT_RST  = 9'd320;
    localparam logic [8:0]  SLEEP_TGT_RST   = 9'd150;
    localparam logic [8:0]  BOOST_TGT_RST   = 9'd400;
    localparam logic [7:0]  TEMP_OFFSET_RST = 8'd0;

    // raw*480/4095 == (raw*32)/273; 1/273 as a 25-bit fraction
    localparam logic [16:0] RECIP_273   = 17'd122910;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [8:0]  DIV_273     = 9'd273;

    localparam logic [11:0]        ADC_TIP_MIN    = 12'd5;
    localparam logic signed [11:0] TEMP_BASE      = 12'sd20;
    localparam logic signed [11:0] OVERHEAT_LIMIT = 12'sd450;
    localparam logic signed [11:0] INTEG_LIMIT    = 12'sd500;
    localparam logic signed [11:0] HEAT_BAND      = 12'sd15;
    localparam logic [7:0]         PWM_MAX        = 8'd255;
    localparam logic [7:0]         PWM_MIN_ON     = 8'd35;

    typedef enum logic [2:0] {
        ST_OVERHEAT = 3'd0,
        ST_TIP      = 3'd1,
        ST_BOOST    = 3'd2,
        ST_SLEEP    = 3'd3,
        ST_HEAT     = 3'd4,
        ST_HOLD     = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP   = 3'd0,
        REG_GAIN_INTEG  = 3'd1,
        REG_GAIN_DERIV  = 3'd2,
        REG_NORMAL_TGT  = 3'd3,
        REG_SLEEP_TGT   = 3'd4,
        REG_BOOST_TGT   = 3'd5,
        REG_TEMP_OFFSET = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]        gain_prop;
        logic [15:0]        gain_integ;
        logic [15:0]        gain_deriv;
        logic [8:0]         normal_target;
        logic [8:0]         sleep_target;
        logic [8:0]         boost_target;
        logic signed [7:0]  temp_offset;
    } cfg_t;

    // classified reading handed from the front end to the control loop
    typedef struct packed {
        status_t            status;
        logic signed [10:0] temp;
        logic [8:0]         target;
    } job_t;

endpackage

// File: hw/rtl/hpid_front.sv
// Front end: converts the ADC reading to degrees and classifies the sample.
// Depends on hpid_pkg.
module hpid_front
    import hpid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] adc_raw,
    input  logic        sleeping,
    input  logic        boost,
    output logic        push_valid,
    output job_t        push_item,
    input  logic        q_full
);

    logic        front_adv;
    logic        f1_valid_reg;
    logic        f2_valid_reg;
    logic [11:0] f1_raw_reg;
    logic [8:0]  f1_q0_reg;
    logic        f1_sleep_reg;
    logic        f1_boost_reg;
    job_t        f2_item_reg;
    job_t        f2_item_next;

    logic [16:0] scaled;
    logic [33:0] recip_prod;

    logic [17:0]        x_ext;
    logic [17:0]        q_times_div;
    logic [17:0]        rem;
    logic [8:0]         quot;
    logic signed [11:0] temp12;
    logic signed [11:0] tgt12;
    logic [8:0]         target;
    logic               tip;

    assign front_adv  = !f2_valid_reg || !q_full;
    assign in_stall   = !front_adv;
    assign push_valid = f2_valid_reg && !q_full;
    assign push_item  = f2_item_reg;

    // quotient estimate, low by at most one
    assign scaled     = {adc_raw, 5'b00000};
    assign recip_prod = {17'b0, scaled} * {17'b0, RECIP_273};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f1_raw_reg   <= adc_raw;
            f1_q0_reg    <= recip_prod[RECIP_SHIFT +: 9];
            f1_sleep_reg <= sleeping;
            f1_boost_reg <= boost;
            f2_item_reg  <= f2_item_next;
        end
    end

    always_comb
    begin
        x_ext       = {1'b0, f1_raw_reg, 5'b00000};
        q_times_div = {9'b0, f1_q0_reg} * {9'b0, DIV_273};
        rem         = x_ext - q_times_div;
        quot        = (rem >= {9'b0, DIV_273}) ? f1_q0_reg + 9'd1 : f1_q0_reg;
        temp12      = $signed({3'b000, quot}) + TEMP_BASE
                    + $signed({{4{cfg.temp_offset[7]}}, cfg.temp_offset});
        tip         = f1_raw_reg < ADC_TIP_MIN;

        target = cfg.normal_target;
        if (f1_sleep_reg)
            target = cfg.sleep_target;
        if (f1_boost_reg)
            target = cfg.boost_target;
        tgt12 = $signed({3'b000, target});

        f2_item_next.temp   = temp12[10:0];
        f2_item_next.target = target;
        if (tip)
        begin
            f2_item_next.status = ST_TIP;
            f2_item_next.temp   = 11'sd0;
        end
        else if (temp12 >= OVERHEAT_LIMIT)
            f2_item_next.status = ST_OVERHEAT;
        else if (f1_boost_reg)
            f2_item_next.status = ST_BOOST;
        else if (f1_sleep_reg)
            f2_item_next.status = ST_SLEEP;
        else if (temp12 + HEAT_BAND < tgt12)
            f2_item_next.status = ST_HEAT;
        else
            f2_item_next.status = ST_HOLD;
    end

endmodule

// File: hw/rtl/hpid_queue.sv
// Short FIFO between the front end and the control loop.
// Depends on hpid_pkg for the entry type.
module hpid_queue
    import hpid_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_item,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: hw/rtl/hpid_back.sv
// Control loop: integral and derivative update, gain products, output shaping.
// Depends on hpid_pkg.
module hpid_back
    import hpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  job_t               q_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         pwm_duty,
    output logic signed [10:0] measured_temp,
    output logic [2:0]         heater_status
);

    logic back_adv;

    // loop state
    logic signed [10:0] integ_reg;
    logic signed [10:0] integ_next;
    logic signed [11:0] prev_err_reg;
    logic signed [11:0] prev_err_next;

    logic               fault;
    logic signed [11:0] err;
    logic signed [11:0] isum;
    logic signed [11:0] deriv;

    logic               b1_valid_reg;
    logic               b1_fault_reg;
    logic signed [11:0] b1_err_reg;
    logic signed [11:0] b1_deriv_reg;
    status_t            b1_status_reg;
    logic signed [10:0] b1_temp_reg;

    logic               b2_valid_reg;
    logic               b2_fault_reg;
    status_t            b2_status_reg;
    logic signed [10:0] b2_temp_reg;
    logic signed [28:0] p_prop_reg;
    logic signed [28:0] p_integ_reg;
    logic signed [28:0] p_deriv_reg;

    logic signed [30:0] pid_sum;
    logic signed [30:0] pid_floor;
    logic [7:0]         pwm_next;

    logic               out_valid_reg;
    logic [7:0]         pwm_reg;
    logic signed [10:0] temp_reg;
    status_t            status_reg;

    assign back_adv = !out_valid_reg || !out_stall;
    assign pop      = back_adv && q_valid;

    assign out_valid     = out_valid_reg;
    assign pwm_duty      = pwm_reg;
    assign measured_temp = temp_reg;
    assign heater_status = status_reg;

    always_comb
    begin
        fault = (q_item.status == ST_TIP) || (q_item.status == ST_OVERHEAT);
        err   = $signed({3'b000, q_item.target}) - {q_item.temp[10], q_item.temp};
        isum  = {integ_reg[10], integ_reg} + err;
        deriv = err - prev_err_reg;

        if (isum > INTEG_LIMIT)
            integ_next = INTEG_LIMIT[10:0];
        else if (isum < -INTEG_LIMIT)
            integ_next = 11'(-INTEG_LIMIT);
        else
            integ_next = isum[10:0];
        prev_err_next = err;

        if (fault)
        begin
            integ_next    = '0;
            prev_err_next = prev_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (pop)
        begin
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_comb
    begin
        pid_sum   = 31'(p_prop_reg) + 31'(p_integ_reg) + 31'(p_deriv_reg);
        pid_floor = pid_sum >>> 8;
        if (b2_fault_reg || pid_floor < 0)
            pwm_next = '0;
        else if (pid_floor > 31'(PWM_MAX))
            pwm_next = PWM_MAX;
        else if (pid_floor < 31'(PWM_MIN_ON) && pid_floor != 0)
            pwm_next = PWM_MIN_ON;
        else
            pwm_next = pid_floor[7:0];
    end

    // stages move in lockstep, so integ_reg still holds the value written
    // by the item now in stage one when its product is taken
    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            b1_fault_reg  <= fault;
            b1_err_reg    <= err;
            b1_deriv_reg  <= deriv;
            b1_status_reg <= q_item.status;
            b1_temp_reg   <= q_item.temp;

            b2_fault_reg  <= b1_fault_reg;
            b2_status_reg <= b1_status_reg;
            b2_temp_reg   <= b1_temp_reg;
            p_prop_reg    <= 29'($signed({1'b0, cfg.gain_prop})) * 29'(b1_err_reg);
            p_integ_reg   <= 29'($signed({1'b0, cfg.gain_integ})) * 29'(integ_reg);
            p_deriv_reg   <= 29'($signed({1'b0, cfg.gain_deriv})) * 29'(b1_deriv_reg);

            pwm_reg    <= pwm_next;
            temp_reg   <= b2_temp_reg;
            status_reg <= b2_status_reg;
        end
    end

endmodule

// File: hw/rtl/heater_pid_with_safety.sv
// Top level of the heater PID controller: configuration registers and wiring
// of front end, queue and control loop. Depends on hpid_pkg, hpid_front,
// hpid_queue and hpid_back.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one averaged ADC reading with
//   the sleeping and boost flags; a transaction completes when in_valid is
//   high and in_stall low. Output channel (out_valid/out_stall) returns one
//   result per reading: pwm_duty, measured_temp and heater_status.
//   Configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   gains, setpoints and offset; cfg_ready is always high, unknown indexes
//   are ignored. Write it only while no reading is in flight.
//   A reading passes conversion stages f1 and f2, the queue, and the
//   control-loop stages b1, b2 and the output register. Throughput is one
//   reading per cycle while in_stall is low; integ_reg updates on each pop.
//   Reset loads the default gains and setpoints, clears the integral and the
//   last error, and empties the queue.
//   A stalled output holds its result and freezes the control loop; the
//   queue and the two front-end stages take up to QUEUE_DEPTH + 2 further
//   readings before in_stall rises.
module heater_pid_with_safety
    import hpid_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [11:0]           adc_raw,
    input  logic                  sleeping,
    input  logic                  boost,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            pwm_duty,
    output logic signed [10:0]    measured_temp,
    output logic [2:0]            heater_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic push_valid;
    job_t push_item;
    logic q_full;
    logic q_valid;
    job_t q_item;
    logic pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop     <= GAIN_PROP_RST;
            cfg_reg.gain_integ    <= GAIN_INTEG_RST;
            cfg_reg.gain_deriv    <= GAIN_DERIV_RST;
            cfg_reg.normal_target <= NORMAL_TGT_RST;
            cfg_reg.sleep_target  <= SLEEP_TGT_RST;
            cfg_reg.boost_target  <= BOOST_TGT_RST;
            cfg_reg.temp_offset   <= TEMP_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_GAIN_PROP:   cfg_reg.gain_prop     <= cfg_data;
                REG_GAIN_INTEG:  cfg_reg.gain_integ    <= cfg_data;
                REG_GAIN_DERIV:  cfg_reg.gain_deriv    <= cfg_data;
                REG_NORMAL_TGT:  cfg_reg.normal_target <= cfg_data[8:0];
                REG_SLEEP_TGT:   cfg_reg.sleep_target  <= cfg_data[8:0];
                REG_BOOST_TGT:   cfg_reg.boost_target  <= cfg_data[8:0];
                REG_TEMP_OFFSET: cfg_reg.temp_offset   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    hpid_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_raw    (adc_raw),
        .sleeping   (sleeping),
        .boost      (boost),
        .push_valid (push_valid),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    hpid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    hpid_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pwm_duty      (pwm_duty),
        .measured_temp (measured_temp),
        .heater_status (heater_status)
    );

endmodule

// File: hw/rtl/hpid_checker.sv
// Port-level checks for the heater PID controller, bound to the top level.
// Depends on assert_macros.svh and hpid_pkg.
`include "assert_macros.svh"

module hpid_checker
    import hpid_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         pwm_duty,
    input logic signed [10:0] measured_temp,
    input logic [2:0]         heater_status
)
;

    logic tip_shown;
    logic hot_shown;

    assign tip_shown = out_valid && heater_status == ST_TIP;
    assign hot_shown = out_valid && heater_status == ST_OVERHEAT;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pwm_duty))
    `ASSERT_NOW(a_pwm_floor, clk, rst_n, out_valid, pwm_duty == 8'd0 || pwm_duty >= PWM_MIN_ON)
    `ASSERT_NOW(a_tip_off, clk, rst_n, tip_shown, pwm_duty == 8'd0 && measured_temp == 11'sd0)
    `ASSERT_NOW(a_hot_off, clk, rst_n, hot_shown, pwm_duty == 8'd0 && measured_temp >= 11'sd450)

endmodule

bind heater_pid_with_safety hpid_checker u_hpid_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pwm_duty      (pwm_duty),
    .measured_temp (measured_temp),
    .heater_status (heater_status)
);
